// ===== hw/rtl/adsyn_pkg.sv =====
// ----------------------------------------------------------------------------
// adsyn_pkg
// Shared widths, opcodes, defaults and control structs for the additive
// synthesiser: partial ring cells, sine/MAC unit and top level.
// ----------------------------------------------------------------------------
package adsyn_pkg;

    // Request and result field widths
    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 4;
    localparam int STEP_W   = 32;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 5;

    // Parameter defaults
    localparam int PARTIALS_DEF     = 16;
    localparam int PHASE_BITS_DEF   = 32;
    localparam int SINE_ENTRIES_DEF = 1024;

    // Fixed-point scales
    localparam int SINE_W     = 16;
    localparam int TERM_W     = 31;
    localparam int SUM_W      = 31;
    localparam int FULL_SCALE = 32767;
    localparam logic signed [SUM_W-1:0] SUM_LIMIT = SUM_W'(1073676289);

    // Opcodes
    localparam logic [OPCODE_W-1:0] OPC_WRITE = 1'b0;
    localparam logic [OPCODE_W-1:0] OPC_TICK  = 1'b1;

    // Control into one ring cell
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Control into the sine/MAC unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

    // Status back from the sine/MAC unit
    typedef struct packed {
        logic busy;
    } mac_stat_t;

endpackage

// ===== hw/rtl/adsyn_if.sv =====
// ----------------------------------------------------------------------------
// adsyn_if
// Valid/ready channels of the synthesiser: request channel and sample channel.
// ----------------------------------------------------------------------------
interface adsyn_req_if;
    logic                        valid;
    logic                        ready;
    logic [adsyn_pkg::OPCODE_W-1:0] opcode;
    logic [adsyn_pkg::INDEX_W-1:0]  partial_index;
    logic [adsyn_pkg::STEP_W-1:0]   phase_step;
    logic [adsyn_pkg::AMP_W-1:0]    amplitude;

    modport source (output valid, opcode, partial_index, phase_step, amplitude,
                    input ready);
    modport sink   (input valid, opcode, partial_index, phase_step, amplitude,
                    output ready);
endinterface

interface adsyn_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [adsyn_pkg::SAMPLE_W-1:0] sample;
    logic                                clipped;

    modport source (output valid, sample, clipped, input ready);
    modport sink   (input valid, sample, clipped, output ready);
endinterface

// ===== hw/rtl/adsyn_cell.sv =====
// ----------------------------------------------------------------------------
// adsyn_cell
// One partial of the oscillator ring: phase, phase step and amplitude.
// Loads from a write request, or takes its neighbour's partial on a shift.
// ----------------------------------------------------------------------------
module adsyn_cell #(
    parameter int PHASE_BITS = adsyn_pkg::PHASE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  adsyn_pkg::cell_ctrl_t        ctrl,
    input  logic [PHASE_BITS-1:0]        wr_step,
    input  logic [adsyn_pkg::AMP_W-1:0]  wr_amp,
    input  logic [PHASE_BITS-1:0]        nb_phase,
    input  logic [PHASE_BITS-1:0]        nb_step,
    input  logic [adsyn_pkg::AMP_W-1:0]  nb_amp,
    output logic [PHASE_BITS-1:0]        phase,
    output logic [PHASE_BITS-1:0]        step,
    output logic [adsyn_pkg::AMP_W-1:0]  amp
);
    import adsyn_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [AMP_W-1:0]      amp_reg;

    // Load a new partial with cleared phase, or take the neighbour's
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            step_reg  <= '0;
            amp_reg   <= '0;
        end
        else if (ctrl.shift)
        begin
            phase_reg <= nb_phase;
            step_reg  <= nb_step;
            amp_reg   <= nb_amp;
        end
        else if (ctrl.load)
        begin
            phase_reg <= '0;
            step_reg  <= wr_step;
            amp_reg   <= wr_amp;
        end
    end

    assign phase = phase_reg;
    assign step  = step_reg;
    assign amp   = amp_reg;

endmodule

// ===== hw/rtl/adsyn_rom.sv =====
// ----------------------------------------------------------------------------
// adsyn_rom
// Full-cycle Q15 sine table, built at elaboration from truncated Taylor
// series in Q30, with a registered read port.
// ----------------------------------------------------------------------------
module adsyn_rom #(
    parameter int SINE_ENTRIES = adsyn_pkg::SINE_ENTRIES_DEF,
    parameter int ADDR_W       = $clog2(SINE_ENTRIES)
) (
    input  logic                                 clk,
    input  logic [ADDR_W-1:0]                    addr,
    output logic signed [adsyn_pkg::SINE_W-1:0]  data
);
    import adsyn_pkg::*;

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] ROUND_Q30    = 64'd1 << 29;
    localparam int          SERIES_TERMS = 12;

    // Factorial steps of the sine and cosine series
    localparam logic [63:0] SIN_DIV [SERIES_TERMS-1] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506};
    localparam logic [63:0] COS_DIV [SERIES_TERMS-1] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462};

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

    // Evaluate sin or cos of a Q30 angle in the first quadrant
    function automatic logic [63:0] series_q30(input logic [63:0] a,
                                               input logic cosine);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        int                 i;
        a2   = (a * a) >> 30;
        term = cosine ? ONE_Q30 : a;
        acc  = $signed(term);
        for (i = 1; i < SERIES_TERMS; i++)
        begin
            if (cosine)
                term = ((term * a2) >> 30) / COS_DIV[i-1];
            else
                term = ((term * a2) >> 30) / SIN_DIV[i-1];
            if ((i % 2) == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        if (acc > $signed(ONE_Q30))
            acc = $signed(ONE_Q30);
        return acc;
    endfunction

    // Fill the table quadrant by quadrant with sign folding
    function automatic sine_tab_t build_table();
        sine_tab_t   tab;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] v;
        logic [63:0] m;
        int          k;
        for (k = 0; k < SINE_ENTRIES; k++)
        begin
            t = 64'(4 * k);
            q = t / SINE_ENTRIES;
            r = t % SINE_ENTRIES;
            a = (HALF_PI_Q30 * r) / SINE_ENTRIES;
            v = series_q30(a, q[0]);
            m = (v * 64'(FULL_SCALE) + ROUND_Q30) >> 30;
            tab[k] = (q >= 64'd2) ? -$signed(SINE_W'(m)) : $signed(SINE_W'(m));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_table();

    // Register the read data
    always_ff @(posedge clk)
    begin
        data <= SINE_TABLE[addr];
    end

endmodule

// ===== hw/rtl/adsyn_mac.sv =====
// ----------------------------------------------------------------------------
// adsyn_mac
// Sine lookup, amplitude multiply and saturating accumulate for the partial
// leaving the head of the ring, then scaling of the sum to a 16-bit sample.
// ----------------------------------------------------------------------------
module adsyn_mac #(
    parameter int PHASE_BITS   = adsyn_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = adsyn_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adsyn_pkg::mac_ctrl_t                  ctrl,
    input  logic [PHASE_BITS-1:0]                 phase,
    input  logic [adsyn_pkg::AMP_W-1:0]           amp,
    output adsyn_pkg::mac_stat_t                  stat,
    output logic signed [adsyn_pkg::SAMPLE_W-1:0] sample,
    output logic                                  clipped
);
    import adsyn_pkg::*;

    localparam int ADDR_W = $clog2(SINE_ENTRIES);
    localparam int ENT_W  = $clog2(SINE_ENTRIES + 1);
    localparam int PROD_W = PHASE_BITS + ENT_W;
    localparam int ACC_W  = SUM_W + 1;
    localparam int QUOT_W = SUM_W - 15;

    // Stage 1: table index and amplitude
    logic [PROD_W-1:0]       index_prod;
    logic [ADDR_W-1:0]       addr_reg;
    logic [AMP_W-1:0]        amp1_reg;
    logic                    v1_reg;
    // Stage 2: sine value (inside the table) and amplitude
    logic signed [SINE_W-1:0] sine_q;
    logic [AMP_W-1:0]        amp2_reg;
    logic                    v2_reg;
    // Stage 3: weighted term
    logic signed [2*SINE_W-1:0] term_full;
    logic signed [TERM_W-1:0] term_reg;
    logic                    v3_reg;
    // Stage 4: running sum
    logic signed [SUM_W-1:0] sum_reg;
    logic                    clip_reg;
    logic signed [ACC_W-1:0] acc_sum;

    // Scaling by 1/32767
    logic [SUM_W-1:0]        mag;
    logic [QUOT_W-1:0]       quot0;
    logic [QUOT_W:0]         rem;
    logic [QUOT_W-1:0]       quot;

    assign index_prod = PROD_W'(phase) * PROD_W'(SINE_ENTRIES);

    adsyn_rom #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .ADDR_W       (ADDR_W)
    ) u_rom (
        .clk  (clk),
        .addr (addr_reg),
        .data (sine_q)
    );

    assign term_full = (2*SINE_W)'(sine_q) * (2*SINE_W)'($signed({1'b0, amp2_reg}));
    assign acc_sum   = ACC_W'(sum_reg) + ACC_W'(term_reg);

    // Advance the valid bits down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Hold the payload stages
    always_ff @(posedge clk)
    begin
        addr_reg <= index_prod[PHASE_BITS +: ADDR_W];
        amp1_reg <= amp;
        amp2_reg <= amp1_reg;
        term_reg <= TERM_W'(term_full);
    end

    // Accumulate with saturation at plus or minus full scale squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else if (v3_reg)
        begin
            if (acc_sum > ACC_W'(SUM_LIMIT))
            begin
                sum_reg  <= SUM_LIMIT;
                clip_reg <= 1'b1;
            end
            else if (acc_sum < -ACC_W'(SUM_LIMIT))
            begin
                sum_reg  <= -SUM_LIMIT;
                clip_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= SUM_W'(acc_sum);
            end
        end
    end

    // Divide the magnitude by 32767: shift estimate, one correction step
    assign mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quot0 = mag[SUM_W-1:15];
    assign rem   = (QUOT_W+1)'(mag[14:0]) + (QUOT_W+1)'(quot0);
    assign quot  = (rem >= (QUOT_W+1)'(FULL_SCALE)) ? quot0 + QUOT_W'(1) : quot0;

    assign sample    = sum_reg[SUM_W-1] ? -$signed(SAMPLE_W'(quot))
                                        : $signed(SAMPLE_W'(quot));
    assign clipped   = clip_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;

endmodule

// ===== hw/rtl/additive_sine_synth.sv =====
// ----------------------------------------------------------------------------
// additive_sine_synth
// Additive synthesiser: a ring of partial cells rotates once per tick request
// and feeds a sine/MAC pipeline that forms one saturated 16-bit sample.
// ----------------------------------------------------------------------------
// Sequence: an accepted tick rotates the whole ring in the run state, waits
// in the drain state until the MAC pipeline is empty, then registers its
// sample in the done state once the output register is free. Requests are
// taken only while idle, so writes go in one per cycle between ticks.
// Reset: all partials, the partial count and the output register clear at
// once; the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module additive_sine_synth #(
    parameter int PARTIALS     = adsyn_pkg::PARTIALS_DEF,
    parameter int PHASE_BITS   = adsyn_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = adsyn_pkg::SINE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    adsyn_req_if.sink                      cmd,
    adsyn_rsp_if.source                    audio,
    input  logic                           cfg_wr_en,
    input  logic [adsyn_pkg::COUNT_W-1:0]  cfg_wr_data
);
    import adsyn_pkg::*;

    localparam int CNT_W = $clog2(PARTIALS + 1);
    localparam int LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          lim_reg;
    logic [COUNT_W-1:0]        active_reg;
    logic                      out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                      clipped_reg;

    logic                      req_fire;
    logic                      tick_fire;
    logic                      write_fire;
    logic                      advance;
    logic                      out_free;
    logic [CNT_W-1:0]          lim_new;

    // Ring storage, one entry per cell
    logic [PHASE_BITS-1:0]     phase_w [PARTIALS];
    logic [PHASE_BITS-1:0]     step_w  [PARTIALS];
    logic [AMP_W-1:0]          amp_w   [PARTIALS];
    logic [PHASE_BITS-1:0]     feed_phase;
    logic [PHASE_BITS-1:0]     wr_step;

    mac_ctrl_t                 mac_ctrl;
    mac_stat_t                 mac_stat;
    logic signed [SAMPLE_W-1:0] mac_sample;
    logic                      mac_clipped;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign req_fire   = cmd.valid && cmd.ready;
    assign tick_fire  = req_fire && (cmd.opcode == OPC_TICK);
    assign write_fire = req_fire && (cmd.opcode == OPC_WRITE);
    assign out_free   = !out_valid_reg || audio.ready;
    assign wr_step    = PHASE_BITS'(cmd.phase_step);

    // Clamp the partial count to the bank size
    assign lim_new = (LIM_W'(active_reg) > LIM_W'(PARTIALS)) ? CNT_W'(PARTIALS)
                                                             : CNT_W'(active_reg);

    // Only active partials at the head contribute and advance
    assign advance    = (state_reg == ST_RUN) && (cnt_reg < lim_reg);
    assign feed_phase = advance ? phase_w[0] + step_w[0] : phase_w[0];

    // Build the ring: each cell takes from the next, the last from the head
    for (genvar i = 0; i < PARTIALS; i++)
    begin : g_cell
        cell_ctrl_t            ctrl;
        logic [PHASE_BITS-1:0] nb_phase;
        logic [PHASE_BITS-1:0] nb_step;
        logic [AMP_W-1:0]      nb_amp;

        assign ctrl.shift = (state_reg == ST_RUN);
        assign ctrl.load  = write_fire && (32'(cmd.partial_index) == i);

        if (i == PARTIALS - 1)
        begin : g_tail
            assign nb_phase = feed_phase;
            assign nb_step  = step_w[0];
            assign nb_amp   = amp_w[0];
        end
        else
        begin : g_body
            assign nb_phase = phase_w[i+1];
            assign nb_step  = step_w[i+1];
            assign nb_amp   = amp_w[i+1];
        end

        adsyn_cell #(
            .PHASE_BITS (PHASE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_step  (wr_step),
            .wr_amp   (cmd.amplitude),
            .nb_phase (nb_phase),
            .nb_step  (nb_step),
            .nb_amp   (nb_amp),
            .phase    (phase_w[i]),
            .step     (step_w[i]),
            .amp      (amp_w[i])
        );
    end

    assign mac_ctrl.clear = tick_fire;
    assign mac_ctrl.valid = advance;

    adsyn_mac #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .phase   (phase_w[0]),
        .amp     (amp_w[0]),
        .stat    (mac_stat),
        .sample  (mac_sample),
        .clipped (mac_clipped)
    );

    // Sequence the tick and hold the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            clipped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                active_reg <= cfg_wr_data;

            if (out_valid_reg && audio.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (tick_fire)
                    begin
                        cnt_reg   <= '0;
                        lim_reg   <= lim_new;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PARTIALS - 1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (!mac_stat.busy)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sample_reg    <= mac_sample;
                        clipped_reg   <= mac_clipped;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign audio.valid   = out_valid_reg;
    assign audio.sample  = sample_reg;
    assign audio.clipped = clipped_reg;

endmodule

// ===== test/adsyn_sample_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsyn_sample_checker
// Watches the request, sample and partial-count ports of the additive
// synthesiser. Keeps its own copy of the partial bank and the sine table,
// predicts the sample of every accepted tick and compares the samples in
// order as they leave the block.
// ----------------------------------------------------------------------------
module adsyn_sample_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    adsyn_req_if                           cmd,
    adsyn_rsp_if                           audio,
    input  logic                           cfg_wr_en,
    input  logic [adsyn_pkg::COUNT_W-1:0]  cfg_wr_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             samples_seen,
    output int                             clips_seen
);
    import adsyn_pkg::*;

    localparam int NPART       = PARTIALS_DEF;
    localparam int PBITS       = PHASE_BITS_DEF;
    localparam int NSINE       = SINE_ENTRIES_DEF;
    localparam int MAX_REPORTS = 10;
    localparam int TAYLOR_LEN  = 12;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned Q30_HALF    = 64'd1 << 29;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          SUM_CAP     = 64'sd1073676289;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } tone_t;

    logic signed [SINE_W-1:0] sine_rom [NSINE];
    logic [PBITS-1:0]         phase_q  [NPART];
    logic [PBITS-1:0]         step_q   [NPART];
    logic [AMP_W-1:0]         amp_q    [NPART];
    logic [COUNT_W-1:0]       partial_count;
    tone_t                    expected_tones [$];
    tone_t                    want;

    // Truncated Taylor series for sin or cos of a Q30 angle, clamped to [0, 1]
    function automatic longint unsigned taylor_q30(input longint unsigned a,
                                                   input bit cosine);
        longint unsigned a2;
        longint unsigned term;
        longint unsigned n;
        longint          acc;
        int              i;
        a2   = (a * a) >> 30;
        term = cosine ? Q30_ONE : a;
        n    = cosine ? 64'd0 : 64'd1;
        acc  = $signed(term);
        for (i = 1; i < TAYLOR_LEN; i++)
        begin
            term = ((term * a2) >> 30) / ((n + 1) * (n + 2));
            n    = n + 2;
            if (i % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > $signed(Q30_ONE))
            acc = $signed(Q30_ONE);
        return $unsigned(acc);
    endfunction

    // Fill the Q15 sine table quadrant by quadrant
    initial
    begin
        longint unsigned t;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned ang;
        longint unsigned v;
        longint          mag;
        for (int k = 0; k < NSINE; k++)
        begin
            t    = 64'(4 * k);
            quad = t / NSINE;
            rem  = t % NSINE;
            ang  = (HALF_PI_Q30 * rem) / NSINE;
            v    = taylor_q30(ang, quad[0]);
            mag  = $signed((v * FULL_SCALE + Q30_HALF) >> 30);
            sine_rom[k] = SINE_W'((quad >= 2) ? -mag : mag);
        end
    end

    // Sum the active partials into one sample and advance their phases
    function automatic tone_t mix_tone();
        tone_t           res;
        int              count;
        longint unsigned ph;
        longint unsigned ti;
        longint          amp_val;
        longint          sine_val;
        longint          prod;
        longint          acc;
        count       = (partial_count > NPART) ? NPART : int'(partial_count);
        acc         = 0;
        res.clipped = 1'b0;
        for (int j = 0; j < count; j++)
        begin
            ph = 64'(phase_q[j]);
            ti = (ph * NSINE) >> PBITS;
            if (ti >= NSINE)
                ti = 64'(NSINE - 1);
            sine_val = 64'(sine_rom[ti]);
            amp_val  = 64'(amp_q[j]);
            prod     = sine_val * amp_val;
            if (acc + prod > SUM_CAP)
            begin
                acc         = SUM_CAP;
                res.clipped = 1'b1;
            end
            else if (acc + prod < -SUM_CAP)
            begin
                acc         = -SUM_CAP;
                res.clipped = 1'b1;
            end
            else
                acc = acc + prod;
            phase_q[j] = phase_q[j] + step_q[j];
        end
        res.sample = SAMPLE_W'(acc / FULL_SCALE);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPART; i++)
            begin
                phase_q[i] = '0;
                step_q[i]  = '0;
                amp_q[i]   = '0;
            end
            partial_count = '0;
            expected_tones.delete();
            mismatches    = 0;
            outstanding   = 0;
            samples_seen  = 0;
            clips_seen    = 0;
        end
        else
        begin
            // Load a partial or predict the sample of a tick
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.opcode == OPC_WRITE)
                begin
                    if (cmd.partial_index < NPART)
                    begin
                        step_q[cmd.partial_index]  = PBITS'(cmd.phase_step);
                        amp_q[cmd.partial_index]   = cmd.amplitude;
                        phase_q[cmd.partial_index] = '0;
                    end
                end
                else
                    expected_tones.push_back(mix_tone());
            end

            // Compare each sample with the oldest prediction
            if (audio.valid && audio.ready)
            begin
                samples_seen++;
                if (audio.clipped)
                    clips_seen++;
                if (expected_tones.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected sample %0d clip %0b at %0t",
                                 audio.sample, audio.clipped, $realtime);
                end
                else
                begin
                    want = expected_tones.pop_front();
                    if (audio.sample !== want.sample || audio.clipped !== want.clipped)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("sample %0d: expected %0d clip %0b, got %0d clip %0b",
                                     samples_seen, want.sample, want.clipped,
                                     audio.sample, audio.clipped);
                    end
                end
            end

            // Track the partial count
            if (cfg_wr_en)
                partial_count = cfg_wr_data;

            outstanding = expected_tones.size();
        end
    end

endmodule

// ===== test/additive_sine_synth_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_sine_synth_tb
// Drives partial writes and tick requests into the additive synthesiser under
// several partial counts, with random gaps on the request side and random
// stalls on the sample side. The checker beside the block predicts and
// compares every sample; this module only makes stimulus and gives verdict.
// ----------------------------------------------------------------------------
module additive_sine_synth_tb;
    import adsyn_pkg::*;

    localparam int  SETTLE_CYCLES = 40;
    localparam int  PHASE_ITEMS   = 85;
    localparam int  PHASE_COUNT   = 6;
    localparam time RUN_LIMIT     = 5_000_000;

    localparam logic [STEP_W-1:0] QUARTER_STEP = 32'h4000_0000;
    localparam logic [STEP_W-1:0] STEP_MAX     = 32'hFFFF_FFFF;
    localparam logic [AMP_W-1:0]  AMP_MAX      = 15'h7FFF;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    bit                 steady;
    int                 req_count;
    int                 tick_count;
    int                 setting_count;
    int                 mismatches;
    int                 outstanding;
    int                 samples_seen;
    int                 clips_seen;

    adsyn_req_if cmd_if ();
    adsyn_rsp_if audio_if ();

    additive_sine_synth DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .audio       (audio_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    adsyn_sample_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_if),
        .audio        (audio_if),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .samples_seen (samples_seen),
        .clips_seen   (clips_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the sample side at random unless a steady stretch is running
    always @(posedge clk)
    begin
        if (!rst_n)
            audio_if.ready <= 1'b0;
        else
            audio_if.ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // Offer one request, idling at random first; valid stays high afterwards
    task automatic send_req(input logic [OPCODE_W-1:0] op,
                            input logic [INDEX_W-1:0]  idx,
                            input logic [STEP_W-1:0]   step,
                            input logic [AMP_W-1:0]    amp);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.opcode        <= op;
        cmd_if.partial_index <= idx;
        cmd_if.phase_step    <= step;
        cmd_if.amplitude     <= amp;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        req_count++;
        if (op == OPC_TICK)
            tick_count++;
    endtask

    // Drop valid and wait until every sample is in and the block is quiet
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Change the partial count while the block is idle
    task automatic set_partials(input logic [COUNT_W-1:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    // One random request: ticks mixed with writes of varied steps and levels
    task automatic send_random();
        logic [STEP_W-1:0] step;
        logic [AMP_W-1:0]  amp;
        case ($urandom_range(0, 3))
            0:       step = $urandom();
            1:       step = STEP_W'($urandom_range(0, 65535));
            2:       step = {4'($urandom_range(0, 15)), 28'h0};
            default: step = STEP_MAX - STEP_W'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 3))
            0:       amp = AMP_W'($urandom_range(0, 32767));
            1:       amp = AMP_MAX;
            2:       amp = AMP_W'($urandom_range(0, 3));
            default: amp = AMP_W'($urandom_range(24000, 32767));
        endcase
        if ($urandom_range(0, 99) < 45)
            send_req(OPC_TICK, INDEX_W'($urandom_range(0, 15)), $urandom(),
                     AMP_W'($urandom_range(0, 32767)));
        else
            send_req(OPC_WRITE, INDEX_W'($urandom_range(0, 15)), step, amp);
    endtask

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [COUNT_W-1:0] settings [PHASE_COUNT];

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.opcode        = OPC_WRITE;
        cmd_if.partial_index = '0;
        cmd_if.phase_step    = '0;
        cmd_if.amplitude     = '0;
        steady               = 1'b0;
        req_count            = 0;
        tick_count           = 0;
        setting_count        = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No active partials straight after reset
        send_req(OPC_TICK, 4'd0, '0, '0);

        // Three full-scale quarter-step partials force both saturation limits
        set_partials(5'd16);
        send_req(OPC_WRITE, 4'd0, QUARTER_STEP, AMP_MAX);
        send_req(OPC_WRITE, 4'd1, QUARTER_STEP, AMP_MAX);
        send_req(OPC_WRITE, 4'd2, QUARTER_STEP, AMP_MAX);
        send_req(OPC_WRITE, 4'd15, STEP_MAX, AMP_MAX);
        send_req(OPC_WRITE, 4'd7, '0, '0);
        repeat (5) send_req(OPC_TICK, 4'd15, STEP_MAX, AMP_MAX);
        send_req(OPC_WRITE, 4'd3, 32'd1, 15'd1);
        send_req(OPC_TICK, 4'd0, '0, '0);

        // Counts above the bank size act as a full bank
        set_partials(5'd17);
        send_req(OPC_TICK, 4'd0, '0, '0);
        send_req(OPC_TICK, 4'd0, '0, '0);
        set_partials(5'd31);
        send_req(OPC_TICK, 4'd0, '0, '0);

        // One partial; a rewrite clears its phase
        set_partials(5'd1);
        send_req(OPC_TICK, 4'd0, '0, '0);
        send_req(OPC_WRITE, 4'd0, QUARTER_STEP, 15'd16384);
        send_req(OPC_TICK, 4'd0, '0, '0);
        send_req(OPC_TICK, 4'd0, '0, '0);

        // Random phases over several partial counts, one without any idling
        settings[0] = 5'd0;
        settings[1] = 5'd16;
        settings[2] = 5'd1;
        settings[3] = 5'd31;
        settings[4] = 5'd17;
        settings[5] = COUNT_W'($urandom_range(2, 15));
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_partials(settings[p]);
            steady = (p == 3);
            repeat (PHASE_ITEMS) send_random();
        end

        steady = 1'b0;
        drain();

        $display("covered %0d requests, %0d ticks over %0d partial-count settings",
                 req_count, tick_count, setting_count);
        $display("compared %0d samples, %0d of them clipped", samples_seen, clips_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/adsyn_pkg.sv
hw/rtl/adsyn_if.sv
hw/rtl/adsyn_cell.sv
hw/rtl/adsyn_rom.sv
hw/rtl/adsyn_mac.sv
hw/rtl/additive_sine_synth.sv
test/adsyn_sample_checker.sv
test/additive_sine_synth_tb.sv
